// ----- rtl/core/nsvd_pkg.sv -----
// ----------------------------------------------------------------------------
// NSV deframer package
// Shared types and constants for the NSV stream deframer.
// ----------------------------------------------------------------------------
package nsvd_pkg;

  // Tag carried with every word that leaves the block.
  typedef enum logic [3:0] {
    KIND_SKIP    = 4'd0,
    KIND_SYNC    = 4'd1,
    KIND_FHDR    = 4'd2,
    KIND_AUXHDR  = 4'd3,
    KIND_AUXDATA = 4'd4,
    KIND_VIDEO   = 4'd5,
    KIND_AUDIO   = 4'd6,
    KIND_PREFIX  = 4'd7,
    KIND_DROP    = 4'd8
  } kind_e;

  localparam logic [31:0] MARK_NSVS = 32'h4E53_5673;
  localparam logic [31:0] FMT_NONE  = 32'h4E4F_4E45;
  localparam logic [31:0] FMT_PCM   = 32'h5043_4D20;
  localparam logic [31:0] FMT_VP61  = 32'h5650_3631;
  localparam logic [31:0] FMT_VP62  = 32'h5650_3632;

  localparam logic [7:0] BYTE_EF    = 8'hEF;
  localparam logic [7:0] BYTE_BE    = 8'hBE;
  localparam logic [7:0] KEY_VP61   = 8'h36;
  localparam logic [7:0] KEY_VP62   = 8'h46;
  localparam logic [3:0] AUX_MASK   = 4'h0F;
  localparam logic [3:0] PCM_PREFIX = 4'd4;

  // One input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       resync;
  } item_t;

  // One tagged result word.
  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      byte_kind;
    logic       first_of_payload;
    logic       last_of_payload;
    logic       keyframe;
    logic       sync_frame;
    logic       length_error;
  } result_t;

endpackage

// ----- rtl/core/nsvd_skid.sv -----
// ----------------------------------------------------------------------------
// NSV deframer input skid buffer
// Two-entry input stage whose stall is taken straight from a register.
// ----------------------------------------------------------------------------
module nsvd_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  nsvd_pkg::item_t in_item_i,
  output logic           item_valid_o,
  input  logic           item_pop_i,
  output nsvd_pkg::item_t item_o
);
  import nsvd_pkg::*;

  item_t main_q;
  item_t spare_q;
  logic  main_valid_q;
  logic  spare_valid_q;
  logic  accept;

  assign in_stall_o   = spare_valid_q;
  assign accept       = in_valid_i && !spare_valid_q;
  assign item_valid_o = main_valid_q;
  assign item_o       = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q  <= 1'b0;
      spare_valid_q <= 1'b0;
    end else if (item_pop_i) begin
      if (spare_valid_q) begin
        main_valid_q  <= 1'b1;
        spare_valid_q <= 1'b0;
      end else begin
        main_valid_q <= accept;
      end
    end else if (accept) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        spare_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_i) begin
      if (spare_valid_q) begin
        main_q <= spare_q;
      end else if (accept) begin
        main_q <= in_item_i;
      end
    end else if (accept) begin
      if (!main_valid_q) begin
        main_q <= in_item_i;
      end else begin
        spare_q <= in_item_i;
      end
    end
  end

endmodule

// ----- rtl/core/nsvd_parser.sv -----
// ----------------------------------------------------------------------------
// NSV deframer parser
// Holds the parse state and tags one word per step.
// ----------------------------------------------------------------------------
module nsvd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  nsvd_pkg::item_t   item_i,
  output nsvd_pkg::result_t result_o
);
  import nsvd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_SYNC   = 4'd1,
    PH_FSTART = 4'd2,
    PH_BEEF2  = 4'd3,
    PH_FHDR   = 4'd4,
    PH_AUXH   = 4'd5,
    PH_AUXD   = 4'd6,
    PH_VID    = 4'd7,
    PH_AUD    = 4'd8
  } phase_e;

  phase_e      phase_q,    phase_d, phase_now;
  logic [31:0] marker_q,   marker_d, marker_now;
  logic [3:0]  cnt_q,      cnt_d;
  logic [31:0] hdr_q,      hdr_d;
  logic [3:0]  aux_q,      aux_d;
  logic [19:0] chunk_q,    chunk_d;
  logic [19:0] vlen_q,     vlen_d;
  logic [15:0] alen_q,     alen_d;
  logic [31:0] vfmt_q,     vfmt_d;
  logic [31:0] afmt_q,     afmt_d;
  logic        fvalid_q,   fvalid_d;
  logic        had_sync_q, had_sync_d;
  logic [7:0]  vbyte1_q,   vbyte1_d;
  logic        lerr_q,     lerr_d;

  logic [7:0]  b;
  logic [19:0] pos;
  logic [16:0] need;
  logic        do_aux_vid;
  logic        do_audio;

  assign b = item_i.in_byte;

  always_comb begin
    phase_now  = phase_q;
    marker_now = marker_q;
    if (item_i.resync) begin
      phase_now  = PH_HUNT;
      marker_now = '0;
    end
    phase_d    = phase_now;
    marker_d   = marker_now;
    cnt_d      = cnt_q;
    hdr_d      = hdr_q;
    aux_d      = aux_q;
    chunk_d    = chunk_q;
    vlen_d     = vlen_q;
    alen_d     = alen_q;
    vfmt_d     = vfmt_q;
    afmt_d     = afmt_q;
    fvalid_d   = fvalid_q;
    had_sync_d = had_sync_q;
    vbyte1_d   = vbyte1_q;
    lerr_d     = lerr_q;
    pos        = vlen_q - chunk_q;
    need       = '0;
    do_aux_vid = 1'b0;
    do_audio   = 1'b0;

    result_o.out_byte         = b;
    result_o.byte_kind        = KIND_SKIP;
    result_o.first_of_payload = 1'b0;
    result_o.last_of_payload  = 1'b0;
    result_o.keyframe         = 1'b0;

    unique case (phase_now)
      PH_HUNT: begin
        marker_d = {marker_now[23:0], b};
        if ({marker_now[23:0], b} == MARK_NSVS) begin
          result_o.byte_kind = KIND_SYNC;
          phase_d    = PH_SYNC;
          cnt_d      = '0;
          had_sync_d = 1'b1;
        end
      end
      PH_SYNC: begin
        result_o.byte_kind = KIND_SYNC;
        hdr_d = {hdr_q[23:0], b};
        if (cnt_q == 4'd3 && !fvalid_q) begin
          vfmt_d = {hdr_q[23:0], b};
        end
        if (cnt_q == 4'd7 && !fvalid_q) begin
          afmt_d = {hdr_q[23:0], b};
        end
        if (cnt_q >= 4'd14) begin
          fvalid_d = 1'b1;
          phase_d  = PH_FHDR;
          cnt_d    = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_FSTART: begin
        if (b == BYTE_EF) begin
          result_o.byte_kind = KIND_FHDR;
          phase_d = PH_BEEF2;
        end else begin
          phase_d  = PH_HUNT;
          marker_d = {24'd0, b};
        end
      end
      PH_BEEF2: begin
        if (b == BYTE_BE) begin
          result_o.byte_kind = KIND_FHDR;
          had_sync_d = 1'b0;
          phase_d    = PH_FHDR;
          cnt_d      = '0;
        end else begin
          phase_d  = PH_HUNT;
          marker_d = {24'd0, b};
        end
      end
      PH_FHDR: begin
        result_o.byte_kind = KIND_FHDR;
        unique case (cnt_q)
          4'd0: begin
            lerr_d = 1'b0;
            aux_d  = b[3:0] & AUX_MASK;
            vlen_d = {16'd0, b[7:4]};
          end
          4'd1:    vlen_d = vlen_q | {8'd0, b, 4'd0};
          4'd2:    vlen_d = vlen_q | {b, 12'd0};
          4'd3:    alen_d = {8'd0, b};
          default: alen_d = alen_q | {b, 8'd0};
        endcase
        if (cnt_q >= 4'd4) begin
          do_aux_vid = 1'b1;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_AUXH: begin
        result_o.byte_kind = KIND_AUXHDR;
        if (cnt_q == 4'd0) begin
          chunk_d = {12'd0, b};
        end else if (cnt_q == 4'd1) begin
          chunk_d = chunk_q | {4'd0, b, 8'd0};
          need    = chunk_d[16:0] + 17'd6;
          if ({3'd0, need} > vlen_q) begin
            lerr_d = 1'b1;
            vlen_d = '0;
          end else begin
            vlen_d = vlen_q - {3'd0, need};
          end
        end
        if (cnt_q >= 4'd5) begin
          aux_d = aux_q - 4'd1;
          if (chunk_d != '0) begin
            phase_d = PH_AUXD;
          end else begin
            do_aux_vid = 1'b1;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      PH_AUXD: begin
        result_o.byte_kind = KIND_AUXDATA;
        chunk_d = chunk_q - 20'd1;
        if (chunk_d == '0) begin
          do_aux_vid = 1'b1;
        end
      end
      PH_VID: begin
        if (vfmt_q == FMT_NONE) begin
          result_o.byte_kind = KIND_DROP;
        end else begin
          result_o.byte_kind        = KIND_VIDEO;
          result_o.first_of_payload = (pos == 20'd0);
          if (pos == 20'd1) begin
            vbyte1_d = b;
          end
          if (chunk_q == 20'd1) begin
            result_o.last_of_payload = 1'b1;
            if (vfmt_q == FMT_VP61) begin
              result_o.keyframe = (vbyte1_d == KEY_VP61);
            end else if (vfmt_q == FMT_VP62) begin
              result_o.keyframe = (vbyte1_d == KEY_VP62);
            end else begin
              result_o.keyframe = had_sync_q;
            end
          end
        end
        chunk_d = chunk_q - 20'd1;
        if (chunk_d == '0) begin
          do_audio = 1'b1;
        end
      end
      PH_AUD: begin
        if (afmt_q == FMT_NONE) begin
          result_o.byte_kind = KIND_DROP;
        end else if (cnt_q != '0) begin
          result_o.byte_kind = KIND_PREFIX;
          cnt_d = cnt_q - 4'd1;
        end else begin
          result_o.byte_kind = KIND_AUDIO;
          if (({4'd0, alen_q} - chunk_q) ==
              ((afmt_q == FMT_PCM) ? {16'd0, PCM_PREFIX} : 20'd0)) begin
            result_o.first_of_payload = 1'b1;
          end
          result_o.last_of_payload = (chunk_q == 20'd1);
        end
        chunk_d = chunk_q - 20'd1;
        if (chunk_d == '0) begin
          phase_d = PH_FSTART;
        end
      end
      default: begin
        phase_d  = PH_HUNT;
        marker_d = {24'd0, b};
      end
    endcase

    // Move on to the next section of the frame that is present.
    if (do_aux_vid) begin
      if (aux_d != '0) begin
        phase_d = PH_AUXH;
        cnt_d   = '0;
      end else if (vlen_d != '0) begin
        phase_d  = PH_VID;
        chunk_d  = vlen_d;
        vbyte1_d = '0;
      end else begin
        do_audio = 1'b1;
      end
    end
    if (do_audio) begin
      if (alen_d != '0) begin
        phase_d = PH_AUD;
        chunk_d = {4'd0, alen_d};
        cnt_d   = (afmt_d == FMT_PCM) ? PCM_PREFIX : 4'd0;
      end else begin
        phase_d = PH_FSTART;
      end
    end

    result_o.sync_frame   = had_sync_d;
    result_o.length_error = lerr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      marker_q   <= '0;
      cnt_q      <= '0;
      hdr_q      <= '0;
      aux_q      <= '0;
      chunk_q    <= '0;
      vlen_q     <= '0;
      alen_q     <= '0;
      vfmt_q     <= '0;
      afmt_q     <= '0;
      fvalid_q   <= 1'b0;
      had_sync_q <= 1'b0;
      vbyte1_q   <= '0;
      lerr_q     <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      marker_q   <= marker_d;
      cnt_q      <= cnt_d;
      hdr_q      <= hdr_d;
      aux_q      <= aux_d;
      chunk_q    <= chunk_d;
      vlen_q     <= vlen_d;
      alen_q     <= alen_d;
      vfmt_q     <= vfmt_d;
      afmt_q     <= afmt_d;
      fvalid_q   <= fvalid_d;
      had_sync_q <= had_sync_d;
      vbyte1_q   <= vbyte1_d;
      lerr_q     <= lerr_d;
    end
  end

endmodule

// ----- rtl/core/nsv_stream_deframer.sv -----
// ----------------------------------------------------------------------------
// NSV stream deframer
// Tags every word of a raw NSV stream with the part of the stream it is in.
// ----------------------------------------------------------------------------
// Usage: raw stream bytes enter on the input channel (in_valid_i, in_stall_o,
// in_byte_i, resync_i), one byte per word. Each accepted word leaves once,
// unchanged, on the output channel (out_valid_o, out_stall_i) together with
// its tag and the payload flags. Raising resync_i with a word sends the
// parser back to marker hunting before that word is looked at, as after a
// seek.
// A word accepted at an edge sits in the skid register until it is parsed, and
// its tagged result is shown from the output register after the edge that ends
// its parse. While the receiver does not stall, the block sustains one word per
// cycle; the single parse step per word, a few narrow adds and compares, sets
// that.
// Reset puts the parser into marker hunting with all lengths, formats and
// flags cleared, and empties both the input and output registers.
// When the receiver stalls, the output word holds; the skid register still
// takes in up to two further words, after which in_stall_o rises, so the
// input stall comes straight from a flip-flop.
module nsv_stream_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       resync_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [3:0] byte_kind_o,
  output logic       first_of_payload_o,
  output logic       last_of_payload_o,
  output logic       keyframe_o,
  output logic       sync_frame_o,
  output logic       length_error_o
);
  import nsvd_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    step;
  result_t result;
  result_t out_q;
  logic    out_valid_q;

  assign in_item.in_byte = in_byte_i;
  assign in_item.resync  = resync_i;

  // A word is parsed whenever the output register is empty or being drained.
  assign step = item_valid && (!out_valid_q || !out_stall_i);

  nsvd_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_pop_i   (step),
    .item_o       (item)
  );

  nsvd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_q.out_byte;
  assign byte_kind_o        = out_q.byte_kind;
  assign first_of_payload_o = out_q.first_of_payload;
  assign last_of_payload_o  = out_q.last_of_payload;
  assign keyframe_o         = out_q.keyframe;
  assign sync_frame_o       = out_q.sync_frame;
  assign length_error_o     = out_q.length_error;

endmodule

// ----- rtl/core/nsvd_checker.sv -----
// ----------------------------------------------------------------------------
// NSV deframer port checker
// Watches the ports of the deframer for tagging and flow control slips.
// ----------------------------------------------------------------------------
module nsvd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [3:0] byte_kind_o,
  input logic       first_of_payload_o,
  input logic       last_of_payload_o,
  input logic       keyframe_o
);
  import nsvd_pkg::*;

  // The input only stalls while a finished word is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
  else $error("input stalled without a held output word");

  // Payload edge flags only ever mark video or audio words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (first_of_payload_o || last_of_payload_o)) |->
      (byte_kind_o == KIND_VIDEO || byte_kind_o == KIND_AUDIO))
  else $error("payload flag on a non-payload word");

  // A keyframe verdict comes only with the last video word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && keyframe_o) |->
      (last_of_payload_o && byte_kind_o == KIND_VIDEO))
  else $error("keyframe outside the last video word");

  // A stalled output word stays and does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(byte_kind_o)))
  else $error("stalled output word changed");

endmodule

bind nsv_stream_deframer nsvd_checker u_nsvd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .out_byte_o         (out_byte_o),
  .byte_kind_o        (byte_kind_o),
  .first_of_payload_o (first_of_payload_o),
  .last_of_payload_o  (last_of_payload_o),
  .keyframe_o         (keyframe_o)
);
